@@ hw/rtl/sckd_pkg.sv @@
// package for the set-1 scan byte decoder: types, codes and translation tables
// no dependencies
package sckd_pkg;

	localparam int ScanW = 8;
	localparam int CharW = 8;
	localparam int SpecW = 5;
	localparam int ModW  = 7;
	localparam int CodeW = 7;
	localparam int SkipW = 3;

	localparam logic [ScanW-1:0] PfxExt   = 8'hE0;
	localparam logic [ScanW-1:0] PfxPause = 8'hE1;

	localparam logic [CodeW-1:0] CdShiftL = 7'h2A;
	localparam logic [CodeW-1:0] CdShiftR = 7'h36;
	localparam logic [CodeW-1:0] CdCtrl   = 7'h1D;
	localparam logic [CodeW-1:0] CdAlt    = 7'h38;
	localparam logic [CodeW-1:0] CdCaps   = 7'h3A;
	localparam logic [CodeW-1:0] CdBksp   = 7'h0E;
	localparam logic [CodeW-1:0] CdEnter  = 7'h1C;
	localparam logic [CodeW-1:0] CdSlash  = 7'h35;
	localparam logic [CodeW-1:0] CdScroll = 7'h46;
	localparam logic [CodeW-1:0] CdPrint  = 7'h37;
	localparam logic [CodeW-1:0] TableLast = 7'h56;

	localparam int MbShift  = 0;
	localparam int MbShiftR = 1;
	localparam int MbCtrl   = 2;
	localparam int MbCtrlR  = 3;
	localparam int MbAlt    = 4;
	localparam int MbAltGr  = 5;
	localparam int MbCaps   = 6;

	typedef enum logic [SpecW-1:0] {
		SP_NONE = 5'd0, SP_BKSP = 5'd1, SP_ENTER = 5'd2, SP_PAUSE = 5'd3,
		SP_PRINT = 5'd4, SP_WINL = 5'd5, SP_WINR = 5'd6, SP_INS = 5'd7,
		SP_DEL = 5'd8, SP_HOME = 5'd9, SP_END = 5'd10, SP_PGUP = 5'd11,
		SP_PGDN = 5'd12, SP_UP = 5'd13, SP_LEFT = 5'd14, SP_DOWN = 5'd15,
		SP_RIGHT = 5'd16
	} special_t;

	typedef struct packed {
		logic [CharW-1:0] char_code;
		logic [SpecW-1:0] special_code;
		logic [ModW-1:0]  modifier_bits;
		logic             released;
	} result_t;

	typedef logic [CharW-1:0] tab_t [0:86];

	localparam tab_t TabPlain = '{
		8'h00,8'h00,8'h31,8'h32,8'h33,8'h34,8'h35,8'h36,8'h37,8'h38,8'h39,8'h30,
		8'hE1,8'h27,8'h00,8'h00,
		8'h71,8'h77,8'h65,8'h72,8'h74,8'h7A,8'h75,8'h69,8'h6F,8'h70,8'h81,8'h2B,
		8'h00,8'h00,8'h61,8'h73,
		8'h64,8'h66,8'h67,8'h68,8'h6A,8'h6B,8'h6C,8'h94,8'h84,8'h5E,8'h00,8'h23,
		8'h79,8'h78,8'h63,8'h76,
		8'h62,8'h6E,8'h6D,8'h2C,8'h2E,8'h2D,8'h00,8'h2A,8'h00,8'h20,8'h00,8'h00,
		8'h00,8'h00,8'h00,8'h00,
		8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h37,8'h38,8'h39,8'h2D,8'h34,
		8'h35,8'h36,8'h2B,8'h31,
		8'h32,8'h33,8'h30,8'h2C,8'h00,8'h00,8'h3C
	};

	localparam tab_t TabShift = '{
		8'h00,8'h00,8'h21,8'h22,8'h00,8'h24,8'h25,8'h26,8'h2F,8'h28,8'h29,8'h3D,
		8'h3F,8'h60,8'h00,8'h00,
		8'h51,8'h57,8'h45,8'h52,8'h54,8'h5A,8'h55,8'h49,8'h4F,8'h50,8'h9A,8'h2A,
		8'h00,8'h00,8'h41,8'h53,
		8'h44,8'h46,8'h47,8'h48,8'h4A,8'h4B,8'h4C,8'h99,8'h8E,8'hF8,8'h00,8'h27,
		8'h59,8'h58,8'h43,8'h56,
		8'h42,8'h4E,8'h4D,8'h3B,8'h3A,8'h5F,8'h00,8'h2A,8'h00,8'h20,8'h00,8'h00,
		8'h00,8'h00,8'h00,8'h00,
		8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h2D,8'h00,
		8'h00,8'h00,8'h2B,8'h00,
		8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h3E
	};

	localparam tab_t TabAltGr = '{
		8'h00,8'h00,8'h00,8'hFD,8'h00,8'hAC,8'hAB,8'hAA,8'h7B,8'h5B,8'h5D,8'h7D,
		8'h5C,8'h00,8'h00,8'h00,
		8'h40,8'h00,8'h00,8'h9E,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h7E,
		8'h00,8'h00,8'h91,8'h00,
		8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
		8'hAF,8'hAE,8'h9B,8'h00,
		8'h00,8'h00,8'hE6,8'hF9,8'h00,8'hC4,8'h00,8'h2A,8'h00,8'h20,8'h00,8'h00,
		8'h00,8'h00,8'h00,8'h00,
		8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h37,8'h38,8'h39,8'h2D,8'h34,
		8'h35,8'h36,8'h2B,8'h31,
		8'h32,8'h33,8'h30,8'h2C,8'h00,8'h00,8'h7C
	};

endpackage

@@ hw/rtl/sckd_xlate.sv @@
// character translation of a plain scan code through the three layout tables
// depends on sckd_pkg
module sckd_xlate (
	input  logic [sckd_pkg::CodeW-1:0] code,
	input  logic [sckd_pkg::ModW-1:0]  mods,
	output logic                       hit,
	output logic [sckd_pkg::CharW-1:0] char_code
);
	import sckd_pkg::*;

	logic [CharW-1:0] plain_c;
	logic             use_shift;
	logic             use_altgr;

	always_comb begin
		plain_c   = '0;
		char_code = '0;
		use_shift = mods[MbShift] | mods[MbShiftR] | mods[MbCaps];
		use_altgr = mods[MbAltGr] | (mods[MbAlt] & (mods[MbCtrl] | mods[MbCtrlR]));
		hit       = 1'b0;
		if (code <= TableLast) begin
			plain_c = TabPlain[code];
			hit     = (plain_c != '0);
			if (use_shift) begin
				char_code = TabShift[code];
			end else if (use_altgr) begin
				char_code = TabAltGr[code];
			end else begin
				char_code = plain_c;
			end
		end
	end
endmodule

@@ hw/rtl/sckd_ext_map.sv @@
// special-key mapping of extended (E0-prefixed) scan codes, plus the keypad slash character
// depends on sckd_pkg
module sckd_ext_map (
	input  logic [sckd_pkg::CodeW-1:0] code,
	output logic                       hit,
	output logic                       start_skip,
	output logic [sckd_pkg::CharW-1:0] char_code,
	output logic [sckd_pkg::SpecW-1:0] special_code
);
	import sckd_pkg::*;

	always_comb begin
		hit          = 1'b1;
		start_skip   = 1'b0;
		char_code    = '0;
		special_code = SP_NONE;
		case (code)
			CdShiftL: begin start_skip = 1'b1; special_code = SP_PRINT; end
			CdPrint:  special_code = SP_PRINT;
			CdScroll: begin start_skip = 1'b1; special_code = SP_PAUSE; end
			7'h5B:    special_code = SP_WINL;
			7'h5C:    special_code = SP_WINR;
			7'h5D:    special_code = SP_BKSP;
			7'h52:    special_code = SP_INS;
			7'h53:    special_code = SP_DEL;
			7'h47:    special_code = SP_HOME;
			7'h4F:    special_code = SP_END;
			7'h49:    special_code = SP_PGUP;
			7'h51:    special_code = SP_PGDN;
			7'h48:    special_code = SP_UP;
			7'h4B:    special_code = SP_LEFT;
			7'h50:    special_code = SP_DOWN;
			7'h4D:    special_code = SP_RIGHT;
			CdSlash:  char_code = 8'h2F;
			default:  hit = 1'b0;
		endcase
	end
endmodule

@@ hw/rtl/scancode_set1_key_decoder_core.sv @@
// set-1 scan byte decoder, top level
// throughput: one word per cycle while m_tready allows, input register then result register
// E0 prefix bytes and swallowed trailing bytes give no result word; the E1 prefix gives a pause result word
// reset (arst_n low, asynchronous) clears decoder state and both valid flags
// depends on sckd_pkg, sckd_xlate, sckd_ext_map
module scancode_set1_key_decoder_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // scan_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // char_code[7:0], special_code[12:8], modifier_bits[19:13], 0
	output logic        m_tuser    // released
);
	import sckd_pkg::*;

	// input stage
	logic             vld_s1;
	logic [ScanW-1:0] byte_s1;
	// result stage
	logic             vld_s2;
	result_t          res_s2;
	// decoder state
	logic             ext_q;
	logic [SkipW-1:0] skip_q;
	logic [ModW-1:0]  mods_q;
	logic [CharW-1:0] char_q;
	logic [SpecW-1:0] spec_q;

	logic             adv_s2, adv_s1;
	logic [CodeW-1:0] code;
	logic             rel;
	logic             x_hit;
	logic [CharW-1:0] x_char;
	logic             e_hit, e_skip;
	logic [CharW-1:0] e_char;
	logic [SpecW-1:0] e_spec;
	logic             ext_d;
	logic [SkipW-1:0] skip_d;
	logic [ModW-1:0]  mods_d;
	logic [CharW-1:0] char_d;
	logic [SpecW-1:0] spec_d;
	logic             emit;

	// result register frees when empty or taken; input stage drains into it
	assign adv_s2   = ~vld_s2 | m_tready;
	assign adv_s1   = adv_s2;
	assign s_tready = ~vld_s1 | adv_s1;

	assign code = byte_s1[CodeW-1:0];
	assign rel  = byte_s1[ScanW-1];

	// character lookup uses modifiers after this byte's own modifier update
	sckd_xlate u_xlate (
		.code      (code),
		.mods      (mods_d),
		.hit       (x_hit),
		.char_code (x_char)
	);

	sckd_ext_map u_ext (
		.code         (code),
		.hit          (e_hit),
		.start_skip   (e_skip),
		.char_code    (e_char),
		.special_code (e_spec)
	);

	always_comb begin
		ext_d  = ext_q;
		skip_d = skip_q;
		mods_d = mods_q;
		char_d = char_q;
		spec_d = spec_q;
		emit   = 1'b0;
		if (skip_q != '0) begin
			// trailing byte of a pause or print-screen sequence
			skip_d = skip_q - 1'b1;
		end else if (byte_s1 == PfxExt) begin
			ext_d = 1'b1;
		end else if (byte_s1 == PfxPause) begin
			skip_d = SkipW'(5);
			char_d = '0;
			spec_d = SP_PAUSE;
			emit   = 1'b1;
		end else if (ext_q) begin
			ext_d = 1'b0;
			emit  = 1'b1;
			if (e_hit) begin
				char_d = e_char;
				spec_d = e_spec;
				if (e_skip) skip_d = SkipW'(2);
			end
			if (code == CdCtrl) mods_d[MbCtrlR] = ~rel;
			else if (code == CdAlt) mods_d[MbAltGr] = ~rel;
		end else begin
			emit = 1'b1;
			case (code)
				CdShiftL: mods_d[MbShift]  = ~rel;
				CdShiftR: mods_d[MbShiftR] = ~rel;
				CdCtrl:   mods_d[MbCtrl]   = ~rel;
				CdAlt:    mods_d[MbAlt]    = ~rel;
				CdCaps:   if (!rel) mods_d[MbCaps] = ~mods_q[MbCaps];
				default:  ;
			endcase
			if (code == CdBksp) begin
				char_d = '0;
				spec_d = SP_BKSP;
			end else if (code == CdEnter) begin
				char_d = '0;
				spec_d = SP_ENTER;
			end else if (x_hit) begin
				char_d = x_char;
				spec_d = SP_NONE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			ext_q  <= 1'b0;
			skip_q <= '0;
			mods_q <= '0;
			char_q <= '0;
			spec_q <= '0;
		end else begin
			if (s_tready) vld_s1 <= s_tvalid;
			if (adv_s2) vld_s2 <= vld_s1 & emit;
			if (vld_s1 && adv_s1) begin
				ext_q  <= ext_d;
				skip_q <= skip_d;
				mods_q <= mods_d;
				char_q <= char_d;
				spec_q <= spec_d;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) byte_s1 <= s_tdata;
		if (adv_s2 && vld_s1) begin
			res_s2.char_code     <= char_d;
			res_s2.special_code  <= spec_d;
			res_s2.modifier_bits <= mods_d;
			res_s2.released      <= (byte_s1 == PfxPause) ? 1'b0 : rel;
		end
	end

	assign m_tvalid = vld_s2;
	assign m_tdata  = {4'b0, res_s2.modifier_bits, res_s2.special_code, res_s2.char_code};
	assign m_tuser  = res_s2.released;
endmodule
